FILE: hw/rtl/two_line_lcd_marquee_macros.svh
// Assertion helpers shared by the marquee RTL.
`ifndef TWO_LINE_LCD_MARQUEE_MACROS_SVH
`define TWO_LINE_LCD_MARQUEE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCDMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCDMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lcdmq_pkg.sv
`timescale 1ns / 1ps
package lcdmq_pkg;

  // Lengths and offsets: a 7-bit length register clipped to the store never exceeds 127.
  localparam int LEN_W      = 7;
  localparam int WRAP_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int MODE_W     = 3;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_ONE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_TWO_LENGTH = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIXED       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCROLL_ONE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCROLL_TWO  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SCROLL_BOTH = 3'd4;

  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_ROW_ONE = 8'h80;
  localparam logic [7:0] CMD_ROW_TWO = 8'h80 | 8'h40;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_TICK,
    JOB_ERROR
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic              first_line;
    logic [LEN_W-1:0]  off_one;
    logic [LEN_W-1:0]  off_two;
    logic [LEN_W-1:0]  len_one;
    logic [LEN_W-1:0]  len_two;
    logic [WRAP_W-1:0] wrap;
  } job_t;

  typedef struct packed {
    logic q_full;
    logic drained;
  } fe_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ERROR,
    BK_CLEAR,
    BK_HOME,
    BK_ROW,
    BK_TEXT
  } bk_state_t;

endpackage

FILE: hw/rtl/two_line_lcd_marquee.sv
`timescale 1ns / 1ps
// Two-line LCD marquee: load text with opcode 0, then a start beat emits clear, home and both
// rows (36 bytes); each tick beat emits a row command and 16 characters per row (34 bytes),
// scrolled per scroll_mode, or a single not_started beat when not running. The byte sequencer
// emits one beat per clock unless the output byte waits untaken; it first fetches the job,
// then emits its bytes, and a two-deep job queue lets the next beats be classified meanwhile.
// A load waits until every earlier draw has finished reading the text store.
module two_line_lcd_marquee #(
  parameter int MAX_TEXT_LENGTH = 64,
  parameter int DISPLAY_COLUMNS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [1:0]                       in_opcode,
  input  logic                             in_line_select,
  input  logic [5:0]                       in_char_position,
  input  logic [7:0]                       in_char_code,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic                             out_is_data,
  output logic [7:0]                       out_lcd_byte,
  output logic [31:0]                      out_wrap_count,
  output logic                             out_not_started,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [lcdmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdmq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lcdmq_pkg::*;

  localparam int AW = $clog2(MAX_TEXT_LENGTH);

  fe_stat_t        stat;
  logic            job_push;
  job_t            job_wr;
  job_t            job_head;
  logic            job_pop;
  logic            q_full;
  logic            q_empty;
  logic            bk_idle;
  logic [1:0]      ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [1:0]      rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data_one;
  logic [7:0]      rd_data_two;

  assign stat.q_full  = q_full;
  assign stat.drained = bk_idle && q_empty;

  lcdmq_front #(
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_line_select  (in_line_select),
    .in_char_position(in_char_position),
    .in_char_code    (in_char_code),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .stat            (stat),
    .job_push        (job_push),
    .job             (job_wr),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata)
  );

  lcdmq_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .push_job(job_wr),
    .pop     (job_pop),
    .head_job(job_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  lcdmq_ram #(
    .WIDTH(8),
    .DEPTH(MAX_TEXT_LENGTH)
  ) u_line_one (
    .clk  (clk),
    .we   (ram_we[0]),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en[0]),
    .raddr(rd_addr),
    .rdata(rd_data_one)
  );

  lcdmq_ram #(
    .WIDTH(8),
    .DEPTH(MAX_TEXT_LENGTH)
  ) u_line_two (
    .clk  (clk),
    .we   (ram_we[1]),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en[1]),
    .raddr(rd_addr),
    .rdata(rd_data_two)
  );

  lcdmq_back #(
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH),
    .DISPLAY_COLUMNS(DISPLAY_COLUMNS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_in         (job_head),
    .job_empty      (q_empty),
    .job_pop        (job_pop),
    .idle           (bk_idle),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data_one    (rd_data_one),
    .rd_data_two    (rd_data_two),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_is_data    (out_is_data),
    .out_lcd_byte   (out_lcd_byte),
    .out_wrap_count (out_wrap_count),
    .out_not_started(out_not_started),
    .out_last       (out_last)
  );

endmodule

FILE: hw/rtl/lcdmq_ram.sv
`timescale 1ns / 1ps
module lcdmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/lcdmq_jobq.sv
`timescale 1ns / 1ps
module lcdmq_jobq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcdmq_pkg::job_t   push_job,
  input  logic              pop,
  output lcdmq_pkg::job_t   head_job,
  output logic              full,
  output logic              empty
);
  import lcdmq_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_job = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = ~wp_r;
    end
    if (pop && !empty) begin
      rp_nxt = ~rp_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/lcdmq_front.sv
`timescale 1ns / 1ps
`include "two_line_lcd_marquee_macros.svh"
module lcdmq_front #(
  parameter int MAX_TEXT_LENGTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [1:0]                         in_opcode,
  input  logic                               in_line_select,
  input  logic [5:0]                         in_char_position,
  input  logic [7:0]                         in_char_code,
  input  logic                               cfg_we,
  input  logic [lcdmq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcdmq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  lcdmq_pkg::fe_stat_t                stat,
  output logic                               job_push,
  output lcdmq_pkg::job_t                    job,
  output logic [1:0]                         ram_we,
  output logic [$clog2(MAX_TEXT_LENGTH)-1:0] ram_waddr,
  output logic [7:0]                         ram_wdata
);
  import lcdmq_pkg::*;

  localparam int AW = $clog2(MAX_TEXT_LENGTH);

  // Holding register for the accepted beat.
  logic        hold_valid_r, hold_valid_nxt;
  logic [1:0]  hold_op_r;
  logic        hold_line_r;
  logic [5:0]  hold_pos_r;
  logic [7:0]  hold_code_r;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [LEN_W-1:0]  len1_r, len1_nxt;
  logic [LEN_W-1:0]  len2_r, len2_nxt;

  logic              running_r, running_nxt;
  logic [LEN_W-1:0]  off1_r, off1_nxt;
  logic [LEN_W-1:0]  off2_r, off2_nxt;
  logic [WRAP_W-1:0] loop_r, loop_nxt;

  logic              accept;
  logic              done;
  logic [LEN_W-1:0]  len1_c, len2_c;
  logic [LEN_W:0]    inc1, inc2;
  logic              wrap1, wrap2;
  logic [LEN_W-1:0]  adv1, adv2;

  assign len1_c = (32'(len1_r) > MAX_TEXT_LENGTH) ? LEN_W'(MAX_TEXT_LENGTH) : len1_r;
  assign len2_c = (32'(len2_r) > MAX_TEXT_LENGTH) ? LEN_W'(MAX_TEXT_LENGTH) : len2_r;

  // An offset runs from zero up to the length inclusive, then wraps.
  assign inc1  = {1'b0, off1_r} + {{LEN_W{1'b0}}, 1'b1};
  assign inc2  = {1'b0, off2_r} + {{LEN_W{1'b0}}, 1'b1};
  assign wrap1 = inc1 > {1'b0, len1_c};
  assign wrap2 = inc2 > {1'b0, len2_c};
  assign adv1  = wrap1 ? '0 : inc1[LEN_W-1:0];
  assign adv2  = wrap2 ? '0 : inc2[LEN_W-1:0];

  assign ram_waddr = AW'(hold_pos_r);
  assign ram_wdata = hold_code_r;

  always_comb begin
    done        = 1'b0;
    job_push    = 1'b0;
    ram_we      = 2'b00;
    running_nxt = running_r;
    off1_nxt    = off1_r;
    off2_nxt    = off2_r;
    loop_nxt    = loop_r;
    job.kind       = JOB_TICK;
    job.first_line = 1'b0;
    job.off_one    = '0;
    job.off_two    = '0;
    job.len_one    = len1_c;
    job.len_two    = len2_c;
    job.wrap       = loop_r;
    if (hold_valid_r) begin
      case (hold_op_r)
        OP_LOAD: begin
          // Text writes wait until every earlier draw has read the store.
          done = stat.drained;
          if (stat.drained && (32'(hold_pos_r) < MAX_TEXT_LENGTH)) begin
            ram_we[hold_line_r] = 1'b1;
          end
        end
        OP_STOP: begin
          done        = 1'b1;
          running_nxt = 1'b0;
        end
        OP_START: begin
          done     = !stat.q_full;
          job_push = !stat.q_full;
          job.kind = JOB_START;
          job.wrap = '0;
          if (!stat.q_full) begin
            running_nxt = 1'b1;
            off1_nxt    = '0;
            off2_nxt    = '0;
            loop_nxt    = '0;
          end
        end
        OP_TICK: begin
          if (!running_r) begin
            done     = !stat.q_full;
            job_push = !stat.q_full;
            job.kind = JOB_ERROR;
          end else if (mode_r == MODE_FIXED) begin
            done     = !stat.q_full;
            job_push = !stat.q_full;
          end else if (mode_r == MODE_SCROLL_ONE) begin
            done        = !stat.q_full;
            job_push    = !stat.q_full;
            job.off_one = adv1;
            job.wrap    = loop_r + WRAP_W'(wrap1);
            if (!stat.q_full) begin
              off1_nxt = adv1;
              loop_nxt = loop_r + WRAP_W'(wrap1);
            end
          end else if (mode_r == MODE_SCROLL_TWO) begin
            done           = !stat.q_full;
            job_push       = !stat.q_full;
            job.first_line = 1'b1;
            job.off_two    = adv2;
            job.wrap       = loop_r + WRAP_W'(wrap2);
            if (!stat.q_full) begin
              off2_nxt = adv2;
              loop_nxt = loop_r + WRAP_W'(wrap2);
            end
          end else if (mode_r == MODE_SCROLL_BOTH) begin
            done        = !stat.q_full;
            job_push    = !stat.q_full;
            job.off_one = adv1;
            job.off_two = adv2;
            job.wrap    = loop_r + WRAP_W'(wrap1) + WRAP_W'(wrap2);
            if (!stat.q_full) begin
              off1_nxt = adv1;
              off2_nxt = adv2;
              loop_nxt = loop_r + WRAP_W'(wrap1) + WRAP_W'(wrap2);
            end
          end else begin
            // Unknown scroll mode: the tick is dropped without a trace.
            done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign in_full = hold_valid_r && !done;
  assign accept  = in_push && !in_full;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (done) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    len1_nxt = len1_r;
    len2_nxt = len2_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SCROLL_MODE:     mode_nxt = cfg_wdata[MODE_W-1:0];
        REG_LINE_ONE_LENGTH: len1_nxt = cfg_wdata;
        REG_LINE_TWO_LENGTH: len2_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      mode_r       <= MODE_FIXED;
      len1_r       <= '0;
      len2_r       <= '0;
      running_r    <= 1'b0;
      off1_r       <= '0;
      off2_r       <= '0;
      loop_r       <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      mode_r       <= mode_nxt;
      len1_r       <= len1_nxt;
      len2_r       <= len2_nxt;
      running_r    <= running_nxt;
      off1_r       <= off1_nxt;
      off2_r       <= off2_nxt;
      loop_r       <= loop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_op_r   <= in_opcode;
      hold_line_r <= in_line_select;
      hold_pos_r  <= in_char_position;
      hold_code_r <= in_char_code;
    end
  end

  `LCDMQ_ASSERT_IMPL(a_load_drained, clk, rst_n, |ram_we, stat.drained,
                     "text store written while a draw is still pending")
  `LCDMQ_ASSERT_IMPL(a_push_room, clk, rst_n, job_push, !stat.q_full,
                     "job pushed into a full queue")

endmodule

FILE: hw/rtl/lcdmq_back.sv
`timescale 1ns / 1ps
`include "two_line_lcd_marquee_macros.svh"
module lcdmq_back #(
  parameter int MAX_TEXT_LENGTH = 64,
  parameter int DISPLAY_COLUMNS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lcdmq_pkg::job_t                    job_in,
  input  logic                               job_empty,
  output logic                               job_pop,
  output logic                               idle,
  output logic [1:0]                         rd_en,
  output logic [$clog2(MAX_TEXT_LENGTH)-1:0] rd_addr,
  input  logic [7:0]                         rd_data_one,
  input  logic [7:0]                         rd_data_two,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic                               out_is_data,
  output logic [7:0]                         out_lcd_byte,
  output logic [31:0]                        out_wrap_count,
  output logic                               out_not_started,
  output logic                               out_last
);
  import lcdmq_pkg::*;

  localparam int AW = $clog2(MAX_TEXT_LENGTH);
  localparam int CW = $clog2(DISPLAY_COLUMNS);
  localparam int SW = ((CW > LEN_W) ? CW : LEN_W) + 1;

  bk_state_t       state_r, state_nxt;
  logic            half_r, half_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  job_t            job_r, job_nxt;

  logic            ov_r;
  logic            o_is_data_r;
  logic [7:0]      o_byte_r;
  logic            o_from_ram_r;
  logic            o_line_r;
  logic [WRAP_W-1:0] o_wrap_r;
  logic            o_ns_r;
  logic            o_last_r;

  logic            step;
  logic            cur_line;
  logic [LEN_W-1:0] cur_len;
  logic [LEN_W-1:0] cur_off;
  logic            col_last;
  logic            in_text;
  logic [SW-1:0]   sum;
  logic [SW-1:0]   idx;

  logic            emit;
  logic            e_is_data;
  logic [7:0]      e_byte;
  logic            e_from_ram;
  logic            e_ns;
  logic            e_last;

  // The output register moves whenever it is empty or being taken.
  assign step     = !ov_r || out_pop;
  assign idle     = (state_r == BK_IDLE);
  assign cur_line = job_r.first_line ^ half_r;
  assign cur_len  = cur_line ? job_r.len_two : job_r.len_one;
  assign cur_off  = cur_line ? job_r.off_two : job_r.off_one;
  assign col_last = (col_r == CW'(DISPLAY_COLUMNS - 1));
  assign in_text  = SW'(col_r) < SW'(cur_len);

  // Column plus offset stays below twice the length, so one subtract wraps it.
  assign sum     = SW'(col_r) + SW'(cur_off);
  assign idx     = (sum >= SW'(cur_len)) ? (sum - SW'(cur_len)) : sum;
  assign rd_addr = AW'(idx);

  always_comb begin
    state_nxt = state_r;
    half_nxt  = half_r;
    col_nxt   = col_r;
    job_nxt   = job_r;
    job_pop   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop  = 1'b1;
          job_nxt  = job_in;
          half_nxt = 1'b0;
          col_nxt  = '0;
          case (job_in.kind)
            JOB_ERROR: state_nxt = BK_ERROR;
            JOB_START: state_nxt = BK_CLEAR;
            default:   state_nxt = BK_ROW;
          endcase
        end
      end
      BK_ERROR: begin
        if (step) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        if (step) begin
          state_nxt = BK_HOME;
        end
      end
      BK_HOME: begin
        if (step) begin
          state_nxt = BK_ROW;
        end
      end
      BK_ROW: begin
        if (step) begin
          state_nxt = BK_TEXT;
          col_nxt   = '0;
        end
      end
      BK_TEXT: begin
        if (step) begin
          if (col_last) begin
            if (half_r) begin
              state_nxt = BK_IDLE;
            end else begin
              half_nxt  = 1'b1;
              state_nxt = BK_ROW;
            end
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    e_is_data  = 1'b0;
    e_byte     = 8'h00;
    e_from_ram = 1'b0;
    e_ns       = 1'b0;
    e_last     = 1'b0;
    rd_en      = 2'b00;
    case (state_r)
      BK_ERROR: begin
        emit   = 1'b1;
        e_ns   = 1'b1;
        e_last = 1'b1;
      end
      BK_CLEAR: begin
        emit   = 1'b1;
        e_byte = CMD_CLEAR;
      end
      BK_HOME: begin
        emit   = 1'b1;
        e_byte = CMD_ROW_ONE;
      end
      BK_ROW: begin
        emit   = 1'b1;
        e_byte = cur_line ? CMD_ROW_TWO : CMD_ROW_ONE;
      end
      BK_TEXT: begin
        emit      = 1'b1;
        e_is_data = 1'b1;
        e_last    = half_r && col_last;
        if (in_text) begin
          e_from_ram      = 1'b1;
          rd_en[cur_line] = step;
        end else begin
          e_byte = SPACE_CHAR;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      half_r  <= 1'b0;
      col_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      half_r  <= half_nxt;
      col_r   <= col_nxt;
      if (step) begin
        ov_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (step) begin
      o_is_data_r  <= e_is_data;
      o_byte_r     <= e_byte;
      o_from_ram_r <= e_from_ram;
      o_line_r     <= cur_line;
      o_wrap_r     <= job_r.wrap;
      o_ns_r       <= e_ns;
      o_last_r     <= e_last;
    end
  end

  assign out_empty       = !ov_r;
  assign out_is_data     = o_is_data_r;
  assign out_lcd_byte    = o_from_ram_r ? (o_line_r ? rd_data_two : rd_data_one) : o_byte_r;
  assign out_wrap_count  = o_wrap_r;
  assign out_not_started = o_ns_r;
  assign out_last        = o_last_r;

  `LCDMQ_ASSERT_IMPL(a_read_in_text, clk, rst_n, |rd_en, state_r == BK_TEXT,
                     "text store read outside a text run")
  `LCDMQ_ASSERT_IMPL(a_pop_when_idle, clk, rst_n, job_pop,
                     state_r == BK_IDLE && !job_empty, "job taken while busy")
  `LCDMQ_ASSERT_NEXT(a_last_ends_run, clk, rst_n, step && emit && e_last,
                     state_r == BK_IDLE, "run continues past its last beat")

endmodule
